@@ sv/mpq_pkg.sv @@
package mpq_pkg;

    // Default capacity of the queue
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int PRI_W     = 8;
    localparam int PAY_W     = 32;
    localparam int OCC_W     = 5;
    localparam int ST_W      = 2;
    localparam int ENTRY_W   = PRI_W + PAY_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Opcodes on the slave-side tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes on the master-side tuser
    localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

endpackage

@@ sv/mpq_ram.sv @@
module mpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/min_priority_queue.sv @@
// Bounded minimum priority queue of DEPTH entries (priority + 32-bit data).
// Slave channel: s_tuser selects insert or remove, s_tdata carries the
// priority and data word of an insert. Master channel: one result per
// transfer in, with the status on m_tuser and the removed entry plus the
// occupancy after the operation on m_tdata.
// Entries sit in one RAM in insertion order. An insert writes the slot at
// the fill count. A remove scans slots 0..count-1 through the registered
// read port, keeps the first lowest priority, then closes the hole by
// copying each later slot one place down (one slot per cycle).
// An insert (also one refused when full) or an empty remove goes from S_IDLE
// straight to S_FIN; a remove with entries held goes through S_SCAN and,
// unless the winner is the last held slot, S_SHIFT before S_FIN. One item
// is in work at a time; s_tready is high only between items.
// A finished result waits in the output register while m_tready is low;
// the block may take the next item meanwhile but holds its own result
// until the output register frees up.
// Reset empties the queue at once (count cleared, RAM contents unused).
module min_priority_queue #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mpq_pkg::S_TDATA_W-1:0]  s_tdata,  // priority_req[7:0], payload[39:8]
    input  logic                           s_tuser,  // opcode[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mpq_pkg::M_TDATA_W-1:0]  m_tdata,  // out_priority[7:0], out_payload[39:8],
                                                     // occupancy[44:40]
    output logic [mpq_pkg::ST_W-1:0]       m_tuser   // status[1:0]
);

    import mpq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = PRI_W + PAY_W + OCC_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_tag_reg, rd_tag_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [PRI_W-1:0]  best_pri_reg, best_pri_next;
    logic [PAY_W-1:0]  best_pay_reg, best_pay_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [PRI_W-1:0]  res_pri_reg, res_pri_next;
    logic [PAY_W-1:0]  res_pay_reg, res_pay_next;
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              in_acc;
    logic [AW-1:0]     last_addr;
    logic [PRI_W-1:0]  rd_pri;
    logic              take;

    mpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign last_addr = AW'(cnt_reg - CW'(1));
    assign rd_pri    = ram_rdata[ENTRY_W-1:PAY_W];
    assign take      = (rd_tag_reg == '0) || (rd_pri < best_pri_reg);

    // Sequencer: accept, scan for the minimum, close the hole, hand off result.
    // Shift reads run ahead of the writes at strictly higher slots, so the
    // same entry is never read and written in one cycle.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        best_pay_next   = best_pay_reg;
        res_status_next = res_status_reg;
        res_pri_next    = res_pri_reg;
        res_pay_next    = res_pay_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = s_tdata[ENTRY_W-1:0];
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[AW-1:0];

        // Drop the output once it has been taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_pri_next = '0;
                    res_pay_next = '0;
                    state_next   = S_FIN;
                    if (s_tuser == OP_INSERT)
                    begin
                        if (cnt_reg >= CW'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = cnt_reg[AW-1:0];
                            ram_wdata       = {s_tdata[PRI_W-1:0],
                                               s_tdata[PRI_W+PAY_W-1:PRI_W]};
                            cnt_next        = cnt_reg + CW'(1);
                            res_status_next = ST_INSERTED;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue reads over the held slots
                if (idx_reg < cnt_reg)
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                // Keep the first lowest priority
                if (rd_vld_reg)
                begin
                    if (take)
                    begin
                        best_idx_next = rd_tag_reg;
                        best_pri_next = rd_pri;
                        best_pay_next = ram_rdata[PAY_W-1:0];
                    end
                    if (rd_tag_reg == last_addr)
                    begin
                        res_status_next = ST_REMOVED;
                        res_pri_next    = best_pri_next;
                        res_pay_next    = best_pay_next;
                        if (best_idx_next == last_addr)
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_FIN;
                        end
                        else
                        begin
                            idx_next   = CW'(best_idx_next) + CW'(1);
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Read the slot above the hole, write it one place down
                if (idx_reg < cnt_reg)
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_tag_reg - AW'(1);
                    ram_wdata = ram_rdata;
                    if (rd_tag_reg == last_addr)
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = {OCC_W'(cnt_reg), res_pay_reg, res_pri_reg};
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track which slot the read data belongs to
    assign rd_vld_next = ram_re;
    assign rd_tag_next = ram_raddr;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rd_tag_reg     <= rd_tag_next;
        best_idx_reg   <= best_idx_next;
        best_pri_reg   <= best_pri_next;
        best_pay_reg   <= best_pay_next;
        res_status_reg <= res_status_next;
        res_pri_reg    <= res_pri_next;
        res_pay_reg    <= res_pay_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, out_data_reg};

endmodule

@@ sv/mpq_chk.sv @@
module mpq_chk #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mpq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mpq_pkg::ST_W-1:0]      m_tuser
);

    import mpq_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a remove carries an entry
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_FULL || m_tuser == ST_EMPTY)
        |-> m_tdata[PRI_W+PAY_W-1:0] == '0)
        else $error("entry fields not zero");

    // Empty remove leaves nothing held
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[PRI_W+PAY_W+OCC_W-1:PRI_W+PAY_W] == '0)
        else $error("empty status with entries held");

    // Full drop reports full capacity
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL
        |-> m_tdata[PRI_W+PAY_W+OCC_W-1:PRI_W+PAY_W] == OCC_W'(DEPTH))
        else $error("full status below capacity");

endmodule

bind min_priority_queue mpq_chk #(.DEPTH(DEPTH)) u_mpq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/mpq_checker.sv @@
// Watches both channels of the priority queue, predicts each result from the
// transfers seen on the slave side and compares it with the master side.
module mpq_checker #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mpq_pkg::S_TDATA_W-1:0]  s_tdata,  // priority_req[7:0], payload[39:8]
    input  logic                           s_tuser,  // opcode[0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mpq_pkg::M_TDATA_W-1:0]  m_tdata,  // out_priority[7:0], out_payload[39:8],
                                                     // occupancy[44:40]
    input  logic [mpq_pkg::ST_W-1:0]       m_tuser,  // status[1:0]
    output int                             fail_count,
    output int                             pending,
    output int                             n_inserted,
    output int                             n_full,
    output int                             n_removed,
    output int                             n_empty
);
    import mpq_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
        logic [OCC_W-1:0] occ;
    } queue_result_t;

    // Shadow copy of the queue contents, oldest entry in slot 0
    logic [PRI_W-1:0] held_pri [DEPTH];
    logic [PAY_W-1:0] held_pay [DEPTH];
    int               held_count;

    queue_result_t    expected_q [$];
    int               fails;
    int               status_tally [4];

    // Apply one request to the shadow queue and return the result it gives
    function automatic queue_result_t apply_request(logic op, logic [PRI_W-1:0] pri,
                                                    logic [PAY_W-1:0] pay);
        queue_result_t r;
        int            best;
        r = '0;
        if (op == OP_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                held_pri[held_count] = pri;
                held_pay[held_count] = pay;
                held_count++;
                r.status = ST_INSERTED;
            end
        end
        else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            // strict less-than keeps the oldest among equal priorities
            best = 0;
            for (int k = 1; k < held_count; k++)
                if (held_pri[k] < held_pri[best])
                    best = k;
            r.pri = held_pri[best];
            r.pay = held_pay[best];
            // close the hole, keeping insertion order
            for (int k = best; k < held_count - 1; k++) begin
                held_pri[k] = held_pri[k + 1];
                held_pay[k] = held_pay[k + 1];
            end
            held_count--;
            r.status = ST_REMOVED;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // Check each result transfer, then predict from each request transfer
    always @(posedge clk or negedge rst_n) begin
        queue_result_t got;
        queue_result_t want;
        if (!rst_n) begin
            expected_q.delete();
            held_count = 0;
            fails = 0;
            for (int k = 0; k < 4; k++)
                status_tally[k] = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.pri    = m_tdata[PRI_W-1:0];
                got.pay    = m_tdata[PRI_W +: PAY_W];
                got.occ    = m_tdata[PRI_W + PAY_W +: OCC_W];
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, status %0d priority %0h data %0h",
                             $time, got.status, got.pri, got.pay);
                    fails++;
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("status", PAY_W'(want.status), PAY_W'(got.status));
                    check_field("out_priority", PAY_W'(want.pri), PAY_W'(got.pri));
                    check_field("out_payload", want.pay, got.pay);
                    check_field("occupancy", PAY_W'(want.occ), PAY_W'(got.occ));
                    status_tally[want.status]++;
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tuser, s_tdata[PRI_W-1:0],
                                                   s_tdata[PRI_W +: PAY_W]));
        end
        fail_count <= fails;
        pending    <= expected_q.size();
        n_inserted <= status_tally[ST_INSERTED];
        n_full     <= status_tally[ST_FULL];
        n_removed  <= status_tally[ST_REMOVED];
        n_empty    <= status_tally[ST_EMPTY];
    end

endmodule

@@ test/testbench.sv @@
// Drives insert and remove requests into the priority queue with random
// gaps and back-pressure; the checker beside the block predicts and compares.
module testbench;
    import mpq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 2 * DEPTH + 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // priority_req[7:0], payload[39:8]
    logic                  s_tuser  = OP_INSERT;  // opcode[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // out_priority[7:0], out_payload[39:8], occupancy[44:40]
    logic [ST_W-1:0]       m_tuser;  // status[1:0]

    int fail_count;
    int pending;
    int n_inserted;
    int n_full;
    int n_removed;
    int n_empty;

    int  cycles    = 0;
    int  sent      = 0;
    int  ready_gap = 0;
    bit  calm      = 1'b0;

    always #5 clk = ~clk;

    min_priority_queue #(.DEPTH(DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mpq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .n_inserted (n_inserted),
        .n_full     (n_full),
        .n_removed  (n_removed),
        .n_empty    (n_empty)
    );

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    always @(posedge clk or negedge rst_n) begin
        int g;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
        end
        else if (ready_gap > 0) begin
            m_tready  <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else begin
            g = pick_gap();
            m_tready  <= (g == 0);
            ready_gap <= (g > 0) ? g - 1 : 0;
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the transfer
    task automatic send_request(logic op, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, pri};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic run_phase(int count, int insert_pct, int pri_max, bit no_gaps);
        logic op;
        calm = no_gaps;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_request(op, PRI_W'($urandom_range(0, pri_max)), $urandom);
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [PRI_W-1:0] dir_pri [16] = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd254, 8'd128,
                                           8'd7, 8'hAA, 8'h55, 8'd0, 8'd200, 8'd64, 8'd3,
                                           8'd128, 8'd9};
        logic [PAY_W-1:0] dir_pay [6]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                           32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty remove, fill with extremes and ties, full insert, removes
        send_request(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_request(OP_INSERT, dir_pri[i], (i < 6) ? dir_pay[i] : $urandom);
        send_request(OP_INSERT, 8'd0, 32'h1234_5678);
        repeat (4) send_request(OP_REMOVE, '0, '0);
        drain();

        // Random phases with shifting insert/remove balance and priority spread
        run_phase(300, 50, 255, 1'b0);
        run_phase(300, 75, 255, 1'b0);
        drain();
        run_phase(300, 30, 3, 1'b0);
        run_phase(300, 55, 255, 1'b1);
        drain();
        run_phase(300, 60, 15, 1'b0);
        run_phase(300, 45, 255, 1'b0);

        // Wind down
        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests: %0d inserted, %0d dropped when full,", sent, n_inserted,
                 n_full);
        $display("%0d removed in priority order, %0d removes on an empty queue", n_removed,
                 n_empty);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
